// ----- rtl/core/brts_pkg.sv -----
// Shared types, constants and fixed-point helpers for the bordered tridiagonal solver.
package brts_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_BORDER = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int S_W        = (MAX_BORDER > 1) ? $clog2(MAX_BORDER) : 1;
    localparam int BC_W       = $clog2(MAX_BORDER + 1);
    localparam int K_DEPTH    = (1 << S_W) * MAX_ROWS;
    localparam int DIV_W      = DATA_W + FRAC_BITS + 1;
    localparam int DCNT_W     = $clog2(DIV_W + 1);
    localparam int ROWD_W     = 4 * DATA_W;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_PIVOT = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower_coef;
        logic signed [DATA_W-1:0] diag_coef;
        logic signed [DATA_W-1:0] upper_coef;
        logic signed [DATA_W-1:0] rhs_value;
        logic signed [DATA_W-1:0] border_coef;
        logic                     last_row;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] solution_value;
        logic [ROW_W-1:0]         row_index;
        logic [1:0]               status;
        logic                     last_result;
    } t_out;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_RD_FWD, OP_LD_ROW, OP_SET_M0, OP_MUL_AQ, OP_SET_M,
        OP_MUL_AP, OP_SET_NUM, OP_DIV_P, OP_WR_P, OP_DIV_Q, OP_LD_Q, OP_RD_KF,
        OP_MUL_AK, OP_DIV_K, OP_WR_K, OP_WR_Q, OP_RD_PL, OP_X_FIRST, OP_RD_BACK,
        OP_LD_BACK, OP_MUL_QX, OP_ADD_X0, OP_RD_KB, OP_MUL_KX, OP_ADD_X, OP_WR_X,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] idx;
        logic [BC_W-1:0]  sidx;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic            div_done;
        logic [BC_W-1:0] bc;
        logic            k_hit;
    } t_sts;

    function automatic logic signed [DATA_W-1:0] fx_add(
        input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_sub(
        input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_neg(input logic signed [DATA_W-1:0] a);
        return fx_sub('0, a);
    endfunction

    // rounded Q product: add half LSB, floor shift, saturate
    function automatic logic signed [DATA_W-1:0] fx_mul(
        input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
        logic signed [2*DATA_W-1:0] pr;
        logic signed [2*DATA_W-1:0] hi;
        logic signed [2*DATA_W-1:0] lo;
        pr = a * b;
        pr = pr + (64'sd1 <<< (FRAC_BITS - 1));
        pr = pr >>> FRAC_BITS;
        hi = {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = ~hi;
        if (pr > hi) return {1'b0, {(DATA_W-1){1'b1}}};
        if (pr < lo) return {1'b1, {(DATA_W-1){1'b0}}};
        return pr[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/core/brts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brts_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/brts_div.sv -----
// Bit-serial signed Q divider with round-half-away and saturation.
module brts_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [brts_pkg::DATA_W-1:0] i_num,
    input  logic signed [brts_pkg::DATA_W-1:0] i_den,
    output logic                              o_done,
    output logic signed [brts_pkg::DATA_W-1:0] o_quo
);
    localparam int DW = brts_pkg::DATA_W;
    localparam int QW = brts_pkg::DIV_W;

    logic                        r_run, r_fin, r_neg;
    logic [brts_pkg::DCNT_W-1:0] r_cnt;
    logic [QW-1:0]               r_dvd, r_qm;
    logic [DW-1:0]               r_rem, r_ud;
    logic [DW-1:0]               w_un, w_ud;
    logic [DW:0]                 w_trial;
    logic                        w_bit;
    logic [DW:0]                 w_qc;

    assign w_un    = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign w_ud    = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_bit   = (w_trial >= {1'b0, r_ud});
    // clamp magnitude to 2^31 before applying the sign
    assign w_qc    = (r_qm > QW'({1'b1, {(DW-1){1'b0}}})) ? {2'b01, {(DW-1){1'b0}}}
                                                          : r_qm[DW:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run  <= (i_den != '0);
                o_done <= (i_den == '0);
            end else if (r_run && r_cnt == brts_pkg::DCNT_W'(1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end else if (r_fin) begin
                o_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
            r_ud  <= w_ud;
            r_rem <= '0;
            r_qm  <= '0;
            r_cnt <= brts_pkg::DCNT_W'(QW);
            r_dvd <= QW'({w_un, {brts_pkg::FRAC_BITS{1'b0}}}) + QW'(w_ud >> 1);
            if (i_den == '0) begin
                if (i_num[DW-1])      o_quo <= {1'b1, {(DW-1){1'b0}}};
                else if (i_num != '0) o_quo <= {1'b0, {(DW-1){1'b1}}};
                else                  o_quo <= '0;
            end
        end else if (r_run) begin
            r_rem <= w_bit ? DW'(w_trial - {1'b0, r_ud}) : w_trial[DW-1:0];
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_qm  <= {r_qm[QW-2:0], w_bit};
            r_cnt <= r_cnt - 1'b1;
        end else if (r_fin) begin
            if (r_neg)        o_quo <= DW'(-w_qc);
            else if (w_qc[DW-1]) o_quo <= {1'b0, {(DW-1){1'b1}}};
            else              o_quo <= w_qc[DW-1:0];
        end
    end
endmodule

// ----- rtl/core/brts_ctrl.sv -----
// Sequencer for row intake, forward sweep and back substitution.
module brts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_row,
    input  brts_pkg::t_sts   i_sts,
    output brts_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    localparam int RW = brts_pkg::ROW_W;
    localparam int BW = brts_pkg::BC_W;

    typedef enum logic [31:0] {
        S_IDLE   = 32'h0000_0001, S_F_RD   = 32'h0000_0002, S_F_LD   = 32'h0000_0004,
        S_F_M0   = 32'h0000_0008, S_F_MA   = 32'h0000_0010, S_F_MB   = 32'h0000_0020,
        S_F_MC   = 32'h0000_0040, S_F_MD   = 32'h0000_0080, S_F_PDIV = 32'h0000_0100,
        S_F_PWT  = 32'h0000_0200, S_F_PWR  = 32'h0000_0400, S_F_QDIV = 32'h0000_0800,
        S_F_QWT  = 32'h0000_1000, S_F_QLD  = 32'h0000_2000, S_F_KRD  = 32'h0000_4000,
        S_F_KMUL = 32'h0000_8000, S_F_KDIV = 32'h0001_0000, S_F_KWT  = 32'h0002_0000,
        S_F_KWR  = 32'h0004_0000, S_F_QWR  = 32'h0008_0000, S_B_INIT = 32'h0010_0000,
        S_B_FST  = 32'h0020_0000, S_B_RD   = 32'h0040_0000, S_B_LD   = 32'h0080_0000,
        S_B_MUL  = 32'h0100_0000, S_B_ADD  = 32'h0200_0000, S_B_CHK  = 32'h0400_0000,
        S_B_KRD  = 32'h0800_0000, S_B_KMUL = 32'h1000_0000, S_B_KADD = 32'h2000_0000,
        S_B_WR   = 32'h4000_0000, S_DONE   = 32'h8000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [RW-1:0]   r_idx, n_idx, r_rows, n_rows, r_nlast, n_nlast;
    logic [BW-1:0]   r_s, n_s;
    logic            w_accept, w_last;
    logic [BW-1:0]   w_s1;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_last   = i_last_row || (r_rows == RW'(brts_pkg::MAX_ROWS - 1));
    assign w_s1     = r_s + 1'b1;
    assign o_busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_rows  <= '0;
            r_nlast <= '0;
            r_s     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rows  <= n_rows;
            r_nlast <= n_nlast;
            r_s     <= n_s;
        end
    end

    // next state and command decode
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_rows    = r_rows;
        n_nlast   = r_nlast;
        n_s       = r_s;
        o_cmd.op  = brts_pkg::OP_NOP;
        o_cmd.idx = r_idx;
        o_cmd.sidx = r_s;
        o_cmd.last = w_last;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idx = r_rows;
                if (w_accept) begin
                    o_cmd.op = brts_pkg::OP_LOAD;
                    n_rows   = r_rows + 1'b1;
                    if (w_last) begin
                        n_nlast = r_rows;
                        n_rows  = '0;
                        n_idx   = '0;
                        n_state = S_F_RD;
                    end
                end
            end
            S_F_RD: begin
                o_cmd.op = brts_pkg::OP_RD_FWD;
                n_state  = S_F_LD;
            end
            S_F_LD: begin
                o_cmd.op = brts_pkg::OP_LD_ROW;
                n_state  = (r_idx == '0) ? S_F_M0 : S_F_MA;
            end
            S_F_M0: begin
                o_cmd.op = brts_pkg::OP_SET_M0;
                n_state  = S_F_PDIV;
            end
            S_F_MA: begin
                o_cmd.op = brts_pkg::OP_MUL_AQ;
                n_state  = S_F_MB;
            end
            S_F_MB: begin
                o_cmd.op = brts_pkg::OP_SET_M;
                n_state  = S_F_MC;
            end
            S_F_MC: begin
                o_cmd.op = brts_pkg::OP_MUL_AP;
                n_state  = S_F_MD;
            end
            S_F_MD: begin
                o_cmd.op = brts_pkg::OP_SET_NUM;
                n_state  = S_F_PDIV;
            end
            S_F_PDIV: begin
                o_cmd.op = brts_pkg::OP_DIV_P;
                n_state  = S_F_PWT;
            end
            S_F_PWT: begin
                if (i_sts.div_done) n_state = S_F_PWR;
            end
            S_F_PWR: begin
                o_cmd.op = brts_pkg::OP_WR_P;
                n_state  = (r_idx == r_nlast) ? S_B_INIT : S_F_QDIV;
            end
            S_F_QDIV: begin
                o_cmd.op = brts_pkg::OP_DIV_Q;
                n_state  = S_F_QWT;
            end
            S_F_QWT: begin
                if (i_sts.div_done) n_state = S_F_QLD;
            end
            S_F_QLD: begin
                o_cmd.op = brts_pkg::OP_LD_Q;
                n_s      = '0;
                if (i_sts.bc == '0)    n_state = S_F_QWR;
                else if (r_idx == '0)  n_state = S_F_KDIV;
                else                   n_state = S_F_KRD;
            end
            S_F_KRD: begin
                o_cmd.op = brts_pkg::OP_RD_KF;
                n_state  = S_F_KMUL;
            end
            S_F_KMUL: begin
                o_cmd.op = brts_pkg::OP_MUL_AK;
                n_state  = S_F_KDIV;
            end
            S_F_KDIV: begin
                o_cmd.op = brts_pkg::OP_DIV_K;
                n_state  = S_F_KWT;
            end
            S_F_KWT: begin
                if (i_sts.div_done) n_state = S_F_KWR;
            end
            S_F_KWR: begin
                o_cmd.op = brts_pkg::OP_WR_K;
                n_s      = w_s1;
                if (w_s1 == i_sts.bc)  n_state = S_F_QWR;
                else if (r_idx == '0)  n_state = S_F_KDIV;
                else                   n_state = S_F_KRD;
            end
            S_F_QWR: begin
                o_cmd.op = brts_pkg::OP_WR_Q;
                n_idx    = r_idx + 1'b1;
                n_state  = S_F_RD;
            end
            S_B_INIT: begin
                o_cmd.op = brts_pkg::OP_RD_PL;
                n_state  = S_B_FST;
            end
            S_B_FST: begin
                o_cmd.op = brts_pkg::OP_X_FIRST;
                n_idx    = r_idx - 1'b1;
                n_state  = (r_idx == '0) ? S_DONE : S_B_RD;
            end
            S_B_RD: begin
                o_cmd.op = brts_pkg::OP_RD_BACK;
                n_state  = S_B_LD;
            end
            S_B_LD: begin
                o_cmd.op = brts_pkg::OP_LD_BACK;
                n_state  = S_B_MUL;
            end
            S_B_MUL: begin
                o_cmd.op = brts_pkg::OP_MUL_QX;
                n_state  = S_B_ADD;
            end
            S_B_ADD: begin
                o_cmd.op = brts_pkg::OP_ADD_X0;
                n_s      = '0;
                n_state  = S_B_CHK;
            end
            S_B_CHK: begin
                if (r_s == i_sts.bc)  n_state = S_B_WR;
                else if (i_sts.k_hit) n_state = S_B_KRD;
                else                  n_s = w_s1;
            end
            S_B_KRD: begin
                o_cmd.op = brts_pkg::OP_RD_KB;
                n_state  = S_B_KMUL;
            end
            S_B_KMUL: begin
                o_cmd.op = brts_pkg::OP_MUL_KX;
                n_state  = S_B_KADD;
            end
            S_B_KADD: begin
                o_cmd.op = brts_pkg::OP_ADD_X;
                n_s      = w_s1;
                n_state  = S_B_CHK;
            end
            S_B_WR: begin
                o_cmd.op = brts_pkg::OP_WR_X;
                n_idx    = r_idx - 1'b1;
                n_state  = (r_idx == '0) ? S_DONE : S_B_RD;
            end
            S_DONE: begin
                o_cmd.op = brts_pkg::OP_CLEAR;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/core/brts_dp.sv -----
// Datapath: row and sweep memories, border registers, multiplier, divider, result register.
module brts_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brts_pkg::t_in  i_item,
    input  brts_pkg::t_cmd i_cmd,
    output brts_pkg::t_sts o_sts,
    output logic           o_strobe,
    output brts_pkg::t_out o_result
);
    localparam int DW = brts_pkg::DATA_W;
    localparam int RW = brts_pkg::ROW_W;
    localparam int SW = brts_pkg::S_W;
    localparam int BW = brts_pkg::BC_W;
    localparam int KW = $clog2(brts_pkg::K_DEPTH);

    logic signed [DW-1:0] r_a, r_b, r_c, r_d, r_m, r_num, r_pp, r_qp, r_x1, r_x, r_q, r_prod;
    logic signed [DW-1:0] r_bval [brts_pkg::MAX_BORDER];
    logic [RW-1:0]        r_col  [brts_pkg::MAX_BORDER];
    logic [BW-1:0]        r_bc;
    logic                 r_ovf, r_pz;

    logic [brts_pkg::ROWD_W-1:0] w_row;
    logic signed [DW-1:0] w_p, w_q, w_k, w_x;
    logic signed [DW-1:0] w_ma, w_mb, w_dnum, w_quo, w_kdat, w_xdat;
    logic                 w_dstart, w_ddone, w_pwe, w_qwe, w_kwe, w_xwe, w_emit;
    logic [RW-1:0]        w_prev, w_next, w_col, w_prd, w_xrd;
    logic [KW-1:0]        w_kwa, w_kra;
    logic [SW-1:0]        w_s;
    logic [RW:0]          w_idx1;
    logic                 w_lt, w_eq, w_cap;

    assign w_s    = i_cmd.sidx[SW-1:0];
    assign w_col  = r_col[w_s];
    assign w_prev = i_cmd.idx - 1'b1;
    assign w_next = i_cmd.idx + 1'b1;
    assign w_idx1 = {1'b0, i_cmd.idx} + {{RW{1'b0}}, 1'b1};
    assign w_lt   = w_idx1 < {1'b0, w_col};
    assign w_eq   = w_idx1 == {1'b0, w_col};

    assign o_sts.div_done = w_ddone;
    assign o_sts.bc       = r_bc;
    assign o_sts.k_hit    = w_idx1 <= {1'b0, w_col};

    // memory controls
    assign w_pwe  = (i_cmd.op == brts_pkg::OP_WR_P);
    assign w_qwe  = (i_cmd.op == brts_pkg::OP_WR_Q);
    assign w_kwe  = (i_cmd.op == brts_pkg::OP_WR_K);
    assign w_emit = (i_cmd.op == brts_pkg::OP_X_FIRST) || (i_cmd.op == brts_pkg::OP_WR_X);
    assign w_xwe  = w_emit;
    assign w_xdat = (i_cmd.op == brts_pkg::OP_X_FIRST) ? w_p : r_x;
    assign w_kdat = w_lt ? w_quo : '0;
    assign w_kwa  = {w_s, i_cmd.idx};
    assign w_kra  = (i_cmd.op == brts_pkg::OP_RD_KF) ? {w_s, w_prev} : {w_s, i_cmd.idx};
    assign w_prd  = (i_cmd.op == brts_pkg::OP_RD_FWD) ? w_prev : i_cmd.idx;
    assign w_xrd  = (i_cmd.op == brts_pkg::OP_RD_KB) ? w_col : w_next;
    assign w_cap  = (i_cmd.op == brts_pkg::OP_LOAD) && !i_cmd.last
                    && (i_cmd.idx >= RW'(2)) && (i_item.border_coef != '0);

    brts_ram #(.W(brts_pkg::ROWD_W), .D(brts_pkg::MAX_ROWS)) u_row_ram (
        .i_clk(i_clk), .i_we(i_cmd.op == brts_pkg::OP_LOAD), .i_waddr(i_cmd.idx),
        .i_wdata({i_item.lower_coef, i_item.diag_coef, i_item.upper_coef, i_item.rhs_value}),
        .i_raddr(i_cmd.idx), .o_rdata(w_row)
    );
    brts_ram #(.W(DW), .D(brts_pkg::MAX_ROWS)) u_p_ram (
        .i_clk(i_clk), .i_we(w_pwe), .i_waddr(i_cmd.idx), .i_wdata(w_quo),
        .i_raddr(w_prd), .o_rdata(w_p)
    );
    brts_ram #(.W(DW), .D(brts_pkg::MAX_ROWS)) u_q_ram (
        .i_clk(i_clk), .i_we(w_qwe), .i_waddr(i_cmd.idx), .i_wdata(r_q),
        .i_raddr(w_prd), .o_rdata(w_q)
    );
    brts_ram #(.W(DW), .D(brts_pkg::K_DEPTH)) u_k_ram (
        .i_clk(i_clk), .i_we(w_kwe), .i_waddr(w_kwa), .i_wdata(w_kdat),
        .i_raddr(w_kra), .o_rdata(w_k)
    );
    brts_ram #(.W(DW), .D(brts_pkg::MAX_ROWS)) u_x_ram (
        .i_clk(i_clk), .i_we(w_xwe), .i_waddr(i_cmd.idx), .i_wdata(w_xdat),
        .i_raddr(w_xrd), .o_rdata(w_x)
    );

    // multiplier operand select
    always_comb begin
        w_ma = r_a;
        w_mb = r_qp;
        case (i_cmd.op)
            brts_pkg::OP_MUL_AP: w_mb = r_pp;
            brts_pkg::OP_MUL_AK: w_mb = w_k;
            brts_pkg::OP_MUL_QX: begin
                w_ma = r_qp;
                w_mb = r_x1;
            end
            brts_pkg::OP_MUL_KX: begin
                w_ma = w_k;
                w_mb = w_x;
            end
            default: ;
        endcase
    end

    // divider numerator select
    always_comb begin
        w_dstart = 1'b1;
        case (i_cmd.op)
            brts_pkg::OP_DIV_P: w_dnum = r_num;
            brts_pkg::OP_DIV_Q: w_dnum = brts_pkg::fx_neg(r_c);
            brts_pkg::OP_DIV_K: w_dnum = (i_cmd.idx == '0) ? brts_pkg::fx_neg(r_bval[w_s])
                                                           : brts_pkg::fx_neg(r_prod);
            default: begin
                w_dnum   = r_num;
                w_dstart = 1'b0;
            end
        endcase
    end

    brts_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_dnum),
        .i_den(r_m), .o_done(w_ddone), .o_quo(w_quo)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            brts_pkg::OP_LD_ROW: begin
                {r_a, r_b, r_c, r_d} <= w_row;
                r_pp <= w_p;
                r_qp <= w_q;
            end
            brts_pkg::OP_SET_M0: begin
                r_m   <= r_b;
                r_num <= r_d;
            end
            brts_pkg::OP_MUL_AQ, brts_pkg::OP_MUL_AP, brts_pkg::OP_MUL_AK,
            brts_pkg::OP_MUL_QX, brts_pkg::OP_MUL_KX: r_prod <= brts_pkg::fx_mul(w_ma, w_mb);
            brts_pkg::OP_SET_M:   r_m   <= brts_pkg::fx_add(r_b, r_prod);
            brts_pkg::OP_SET_NUM: r_num <= brts_pkg::fx_sub(r_d, r_prod);
            brts_pkg::OP_LD_Q:    r_q   <= w_quo;
            brts_pkg::OP_WR_K: begin
                if (w_eq) r_q <= brts_pkg::fx_add(r_q, w_quo);
            end
            brts_pkg::OP_LD_BACK: begin
                r_pp <= w_p;
                r_qp <= w_q;
                r_x1 <= w_x;
            end
            brts_pkg::OP_ADD_X0: r_x <= brts_pkg::fx_add(r_pp, r_prod);
            brts_pkg::OP_ADD_X:  r_x <= brts_pkg::fx_add(r_x, r_prod);
            default: ;
        endcase
        if (w_cap && r_bc < BW'(brts_pkg::MAX_BORDER)) begin
            r_bval[r_bc[SW-1:0]] <= i_item.border_coef;
            r_col[r_bc[SW-1:0]]  <= i_cmd.idx;
        end
        if (w_emit) begin
            o_result.solution_value <= w_xdat;
            o_result.row_index      <= i_cmd.idx;
            o_result.status         <= r_pz ? brts_pkg::ST_PIVOT
                                            : (r_ovf ? brts_pkg::ST_OVF : brts_pkg::ST_OK);
            o_result.last_result    <= (i_cmd.idx == '0);
        end
    end

    // border count, flags and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc     <= '0;
            r_ovf    <= 1'b0;
            r_pz     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_emit;
            if (i_cmd.op == brts_pkg::OP_CLEAR) begin
                r_bc  <= '0;
                r_ovf <= 1'b0;
                r_pz  <= 1'b0;
            end else begin
                if (w_cap) begin
                    if (r_bc < BW'(brts_pkg::MAX_BORDER)) r_bc <= r_bc + 1'b1;
                    else                                  r_ovf <= 1'b1;
                end
                if (w_dstart && r_m == '0) r_pz <= 1'b1;
            end
        end
    end
endmodule

// ----- rtl/core/bordered_row_tridiagonal_solver.sv -----
// Top level of the bordered tridiagonal solver.
// Rows are transferred one per cycle while busy is low (start high). The row flagged
// last_row, or the 64th row, starts the solve and raises busy. One shared bit-serial
// divider paces the solve; with a zero divisor it skips the bit-serial steps. A row
// of back substitution adds a multiply-add for each border column at or beyond the
// next row. Results come out from the highest index down to zero, one strobed cycle
// each, with no way to stall them; busy drops the cycle after the result flagged
// last_result.
module bordered_row_tridiagonal_solver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  brts_pkg::t_in  i_item,
    output logic           o_strobe,
    output brts_pkg::t_out o_result
);
    brts_pkg::t_cmd w_cmd;
    brts_pkg::t_sts w_sts;

    brts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last_row(i_item.last_row),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy)
    );

    brts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_strobe(o_strobe), .o_result(o_result)
    );

    // results only appear during a solve
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a solve");

    // the final result ends the solve
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |=> !busy)
        else $error("block still busy after final result");

    // final result carries index zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |-> o_result.row_index == '0)
        else $error("final result not at index zero");
endmodule
